// ----- rtl/rbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// shared types, register indexes and defaults for the box filter downscaler
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam int DEF_MAX_LINE_PIXELS = 1024;
   localparam int DEF_MAX_ROWS        = 512;

   // geometry arithmetic width, holds any clamped size up to 4096
   localparam int GW = 13;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_LINE_PIXELS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_X      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_Y      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_W      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_H      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COLOUR_MODE = 3'd7;

   localparam logic [10:0] RST_LINE_PIXELS = 11'd800;
   localparam logic [9:0]  RST_RECT_X      = 10'd0;
   localparam logic [8:0]  RST_RECT_Y      = 9'd0;
   localparam logic [10:0] RST_RECT_W      = 11'd800;
   localparam logic [9:0]  RST_RECT_H      = 10'd480;
   localparam logic [10:0] RST_OUT_WIDTH   = 11'd320;
   localparam logic [9:0]  RST_OUT_HEIGHT  = 10'd240;

   // step selectors shared by controller and datapath
   localparam logic [1:0] EDGE_CS   = 2'd0;
   localparam logic [1:0] EDGE_CE   = 2'd1;
   localparam logic [1:0] EDGE_RS   = 2'd2;
   localparam logic [1:0] EDGE_RE   = 2'd3;
   localparam logic [1:0] CH_RED    = 2'd0;
   localparam logic [1:0] CH_GREEN  = 2'd1;
   localparam logic [1:0] CH_BLUE   = 2'd2;

   localparam logic [5:0] MAX5 = 6'd31;
   localparam logic [5:0] MAX6 = 6'd63;

   typedef struct packed {
      logic       accept;
      logic       geo;
      logic       eval;
      logic       mul_edge;
      logic       mul_ch;
      logic       div_start;
      logic       store_edge;
      logic       acc;
      logic       area;
      logic       store_ch;
      logic       out_load;
      logic [1:0] sel;
   } rbd_cmd_type;

   typedef struct packed {
      logic hit;
      logic emit;
      logic div_done;
      logic out_free;
   } rbd_stat_type;

endpackage

// ----- rtl/rbd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/rbd_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rbd_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W:0]   rem_sh;
   logic             ge;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      rem_sh = {rem_ff, q_ff[NUM_W-1]};
      ge     = rem_sh >= {1'b0, den};
      rem_in = ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= CNT_W'(NUM_W);
         rem_ff <= '0;
         q_ff   <= num;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         rem_ff <= rem_in;
         q_ff   <= {q_ff[NUM_W-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ----- rtl/rbd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ctrl
// sequencer for one pixel: geometry, box edges, accumulate, averages, result
// ----------------------------------------------------------------------------
module rbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rbd_pkg::rbd_stat_type stat,
   output rbd_pkg::rbd_cmd_type  cmd
);
   import rbd_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'h001,
      ST_GEO    = 12'h002,
      ST_EVAL   = 12'h004,
      ST_EMUL   = 12'h008,
      ST_ESTART = 12'h010,
      ST_EDIV   = 12'h020,
      ST_ACC    = 12'h040,
      ST_AREA   = 12'h080,
      ST_CMUL   = 12'h100,
      ST_CSTART = 12'h200,
      ST_CDIV   = 12'h400,
      ST_OUT    = 12'h800
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cmd       = '0;
      cmd.sel   = sel_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_GEO;
            end
         end
         ST_GEO: begin
            cmd.geo  = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            sel_in   = EDGE_CS;
            state_in = stat.hit ? ST_EMUL : ST_IDLE;
         end
         ST_EMUL: begin
            cmd.mul_edge = 1'b1;
            state_in     = ST_ESTART;
         end
         ST_ESTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_EDIV;
         end
         ST_EDIV: begin
            if (stat.div_done) begin
               cmd.store_edge = 1'b1;
               if (sel_ff == EDGE_RE) begin
                  state_in = ST_ACC;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = ST_EMUL;
               end
            end
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = stat.emit ? ST_AREA : ST_IDLE;
         end
         ST_AREA: begin
            cmd.area = 1'b1;
            sel_in   = CH_RED;
            state_in = ST_CMUL;
         end
         ST_CMUL: begin
            cmd.mul_ch = 1'b1;
            state_in   = ST_CSTART;
         end
         ST_CSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_CDIV;
         end
         ST_CDIV: begin
            if (stat.div_done) begin
               cmd.store_ch = 1'b1;
               if (sel_ff == CH_BLUE) begin
                  state_in = ST_OUT;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = ST_CMUL;
               end
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // a new pixel is only taken in idle, once the previous result has been loaded into the result register
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_GEO)
      else $error("accept did not start geometry step");
   assert property (@(posedge clock) disable iff (reset)
      cmd.store_edge |-> $past(cmd.div_start, 1) == 1'b0)
      else $error("edge stored in the cycle after divider start");
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == ST_IDLE)
      else $error("result load did not return to idle");
endmodule

// ----- rtl/rbd_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_dp
// datapath: config registers, position counters, column sum ram, divider
// ----------------------------------------------------------------------------
module rbd_dp #(
   parameter int MAX_LINE_PIXELS = rbd_pkg::DEF_MAX_LINE_PIXELS,
   parameter int MAX_ROWS        = rbd_pkg::DEF_MAX_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [rbd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbd_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic [15:0]                     req_pixel,
   input  logic                            req_start_of_frame,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_blue,
   output logic [7:0]                      rsp_green,
   output logic [7:0]                      rsp_red,
   output logic [7:0]                      rsp_gray,
   output logic                            rsp_end_of_row,
   output logic                            rsp_end_of_image,
   input  rbd_pkg::rbd_cmd_type            cmd,
   output rbd_pkg::rbd_stat_type           stat
);
   import rbd_pkg::*;

   localparam int COL_W  = $clog2(MAX_LINE_PIXELS);
   localparam int ROW_W  = $clog2(MAX_ROWS) + 1;
   localparam int OC_W   = COL_W + 1;
   localparam int AREA_W = COL_W + ROW_W;
   localparam int SUM_W  = AREA_W + 6;
   localparam int NUM_W  = SUM_W + 8;
   localparam int DEN_W  = AREA_W + 6;
   localparam logic [GW-1:0] MAXLP_G = GW'(MAX_LINE_PIXELS);
   localparam logic [GW-1:0] MAXR_G  = GW'(MAX_ROWS);
   localparam logic [GW-1:0] ONE_G   = GW'(1);

   // configuration
   logic [10:0] line_pixels_ff, rect_w_ff, out_width_ff;
   logic [9:0]  rect_x_ff, rect_h_ff, out_height_ff;
   logic [8:0]  rect_y_ff;
   logic        colour_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pixels_ff <= RST_LINE_PIXELS;
         rect_x_ff      <= RST_RECT_X;
         rect_y_ff      <= RST_RECT_Y;
         rect_w_ff      <= RST_RECT_W;
         rect_h_ff      <= RST_RECT_H;
         out_width_ff   <= RST_OUT_WIDTH;
         out_height_ff  <= RST_OUT_HEIGHT;
         colour_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_LINE_PIXELS: line_pixels_ff <= csr_data[10:0];
            REG_RECT_X:      rect_x_ff      <= csr_data[9:0];
            REG_RECT_Y:      rect_y_ff      <= csr_data[8:0];
            REG_RECT_W:      rect_w_ff      <= csr_data[10:0];
            REG_RECT_H:      rect_h_ff      <= csr_data[9:0];
            REG_OUT_WIDTH:   out_width_ff   <= csr_data[10:0];
            REG_OUT_HEIGHT:  out_height_ff  <= csr_data[9:0];
            REG_COLOUR_MODE: colour_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // position and box state
   logic [COL_W-1:0] c_ff;
   logic [ROW_W-1:0] r_ff;
   logic [OC_W-1:0]  oc_ff;
   logic [ROW_W-1:0] or_ff;
   logic [15:0]      pix_ff;
   logic [GW-1:0]    rw_ff, rh_ff, x_ff, y_ff, ow_ff, oh_ff;
   logic [GW-1:0]    cs_ff, ce_ff, rs_ff, re_ff;
   logic             in_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [AREA_W-1:0] area_ff;
   logic [SUM_W-1:0] sr_ff, sg_ff, sb_ff;
   logic [7:0]       er_ff, eg_ff, eb_ff;
   logic             eor_ff, eoi_ff;

   // geometry
   logic [GW-1:0] line_g, rx_g, ry_g, lp, rw_c, rh_c, c_g, r_g, x_c, y_c;
   logic          act_c, in_c;

   always_comb begin
      line_g = GW'(line_pixels_ff);
      rx_g   = GW'(rect_x_ff);
      ry_g   = GW'(rect_y_ff);
      if (line_g == '0) begin
         lp = ONE_G;
      end else if (line_g > MAXLP_G) begin
         lp = MAXLP_G;
      end else begin
         lp = line_g;
      end
      rw_c  = (GW'(rect_w_ff) < lp - rx_g) ? GW'(rect_w_ff) : lp - rx_g;
      rh_c  = (GW'(rect_h_ff) < MAXR_G - ry_g) ? GW'(rect_h_ff) : MAXR_G - ry_g;
      act_c = rx_g < lp && ry_g < MAXR_G && rw_c != '0 && rh_c != '0;
      c_g   = GW'(c_ff);
      r_g   = GW'(r_ff);
      x_c   = c_g - rx_g;
      y_c   = r_g - ry_g;
      in_c  = act_c && c_g >= rx_g && x_c < rw_c && r_g >= ry_g && y_c < rh_c;
   end

   // output size clamp and box restart
   logic [GW-1:0]    ow_c, oh_c;
   logic [OC_W-1:0]  oc_eff;
   logic [ROW_W-1:0] or_eff;
   logic             hit_c;

   always_comb begin
      if (out_width_ff == '0) begin
         ow_c = ONE_G;
      end else if (GW'(out_width_ff) > rw_ff) begin
         ow_c = rw_ff;
      end else begin
         ow_c = GW'(out_width_ff);
      end
      if (out_height_ff == '0) begin
         oh_c = ONE_G;
      end else if (GW'(out_height_ff) > rh_ff) begin
         oh_c = rh_ff;
      end else begin
         oh_c = GW'(out_height_ff);
      end
      oc_eff = (in_ff && x_ff == '0) ? '0 : oc_ff;
      or_eff = (in_ff && x_ff == '0 && y_ff == '0) ? '0 : or_ff;
      hit_c  = in_ff && GW'(oc_eff) < ow_c && GW'(or_eff) < oh_c;
   end

   // edge and channel multiplies
   logic [GW-1:0]   ma, mb;
   logic [2*GW-1:0] eprod;
   logic [SUM_W-1:0] sum_sel;
   logic [5:0]       max_sel;

   always_comb begin
      ma    = cmd.sel[1] ? GW'(or_ff) + GW'(cmd.sel[0]) : GW'(oc_ff) + GW'(cmd.sel[0]);
      mb    = cmd.sel[1] ? rh_ff : rw_ff;
      eprod = (2*GW)'(ma) * (2*GW)'(mb);
      case (cmd.sel)
         CH_RED: begin
            sum_sel = sr_ff;
            max_sel = MAX5;
         end
         CH_GREEN: begin
            sum_sel = sg_ff;
            max_sel = MAX6;
         end
         default: begin
            sum_sel = sb_ff;
            max_sel = MAX5;
         end
      endcase
   end

   // column sums
   logic [3*SUM_W-1:0] ram_rd, ram_wr;
   logic [SUM_W-1:0]   pr, pg, pb, nr, ng, nb;
   logic               fresh, col_done, emit_c, row_done;

   always_comb begin
      pr       = SUM_W'(pix_ff[15:11]);
      pg       = SUM_W'(pix_ff[10:5]);
      pb       = SUM_W'(pix_ff[4:0]);
      fresh    = y_ff == rs_ff && x_ff == cs_ff;
      nr       = fresh ? pr : ram_rd[3*SUM_W-1:2*SUM_W] + pr;
      ng       = fresh ? pg : ram_rd[2*SUM_W-1:SUM_W] + pg;
      nb       = fresh ? pb : ram_rd[SUM_W-1:0] + pb;
      ram_wr   = {nr, ng, nb};
      col_done = x_ff + ONE_G == ce_ff;
      emit_c   = col_done && y_ff + ONE_G == re_ff;
      row_done = x_ff + ONE_G == rw_ff && y_ff + ONE_G == re_ff;
   end

   rbd_ram #(
      .WIDTH (3 * SUM_W),
      .DEPTH (MAX_LINE_PIXELS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (cmd.acc),
      .wr_addr (oc_ff[COL_W-1:0]),
      .wr_data (ram_wr),
      .rd_en   (cmd.eval),
      .rd_addr (oc_eff[COL_W-1:0]),
      .rd_data (ram_rd)
   );

   logic             div_busy, div_done;
   logic [NUM_W-1:0] div_quot;

   rbd_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   logic [2*GW-1:0] area_prod;
   logic [7:0]      q8;

   always_comb begin
      area_prod = (2*GW)'(ce_ff - cs_ff) * (2*GW)'(re_ff - rs_ff);
      q8        = (|div_quot[NUM_W-1:8]) ? 8'd255 : div_quot[7:0];
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff  <= '0;
         r_ff  <= '0;
         oc_ff <= '0;
         or_ff <= '0;
         in_ff <= 1'b0;
      end else begin
         if (cmd.accept && req_start_of_frame) begin
            c_ff  <= '0;
            r_ff  <= '0;
            oc_ff <= '0;
            or_ff <= '0;
         end
         if (cmd.geo) begin
            in_ff <= in_c;
            if (c_g + ONE_G >= lp) begin
               c_ff <= '0;
               r_ff <= (r_g + ONE_G >= MAXR_G) ? ROW_W'(MAX_ROWS) : r_ff + ROW_W'(1);
            end else begin
               c_ff <= c_ff + COL_W'(1);
            end
         end
         if (cmd.eval) begin
            oc_ff <= oc_eff;
            or_ff <= or_eff;
         end
         if (cmd.acc) begin
            if (col_done) begin
               oc_ff <= oc_ff + OC_W'(1);
            end
            if (row_done) begin
               or_ff <= or_ff + ROW_W'(1);
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= req_pixel;
      end
      if (cmd.geo) begin
         rw_ff <= rw_c;
         rh_ff <= rh_c;
         x_ff  <= x_c;
         y_ff  <= y_c;
      end
      if (cmd.eval) begin
         ow_ff <= ow_c;
         oh_ff <= oh_c;
      end
      if (cmd.mul_edge) begin
         num_ff <= NUM_W'(eprod);
         den_ff <= DEN_W'(cmd.sel[1] ? oh_ff : ow_ff);
      end
      if (cmd.mul_ch) begin
         num_ff <= NUM_W'({sum_sel, 8'd0}) - NUM_W'(sum_sel);
         den_ff <= DEN_W'(area_ff) * DEN_W'(max_sel);
      end
      if (cmd.store_edge) begin
         case (cmd.sel)
            EDGE_CS: cs_ff <= div_quot[GW-1:0];
            EDGE_CE: ce_ff <= div_quot[GW-1:0];
            EDGE_RS: rs_ff <= div_quot[GW-1:0];
            default: re_ff <= div_quot[GW-1:0];
         endcase
      end
      if (cmd.acc) begin
         sr_ff  <= nr;
         sg_ff  <= ng;
         sb_ff  <= nb;
         eor_ff <= GW'(oc_ff) + ONE_G == ow_ff;
         eoi_ff <= GW'(oc_ff) + ONE_G == ow_ff && GW'(or_ff) + ONE_G == oh_ff;
      end
      if (cmd.area) begin
         area_ff <= (area_prod == '0) ? AREA_W'(1) : AREA_W'(area_prod);
      end
      if (cmd.store_ch) begin
         case (cmd.sel)
            CH_RED:   er_ff <= q8;
            CH_GREEN: eg_ff <= q8;
            default:  eb_ff <= q8;
         endcase
      end
   end

   // result register
   logic        rsp_valid_ff;
   logic [7:0]  blue_ff, green_ff, red_ff, gray_ff;
   logic        rsp_eor_ff, rsp_eoi_ff;
   logic [15:0] luma;

   assign luma = 16'(er_ff) * 16'd77 + 16'(eg_ff) * 16'd150 + 16'(eb_ff) * 16'd29;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         blue_ff    <= colour_mode_ff ? eb_ff : 8'd0;
         green_ff   <= colour_mode_ff ? eg_ff : 8'd0;
         red_ff     <= colour_mode_ff ? er_ff : 8'd0;
         gray_ff    <= colour_mode_ff ? 8'd0 : luma[15:8];
         rsp_eor_ff <= eor_ff;
         rsp_eoi_ff <= eoi_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_green        = green_ff;
   assign rsp_red          = red_ff;
   assign rsp_gray         = gray_ff;
   assign rsp_end_of_row   = rsp_eor_ff;
   assign rsp_end_of_image = rsp_eoi_ff;

   assign stat.hit      = hit_c;
   assign stat.emit     = emit_c;
   assign stat.div_done = div_done;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while busy");
   assert property (@(posedge clock) disable iff (reset)
      cmd.mul_ch |-> area_ff != '0)
      else $error("zero box area reached the divider");
endmodule

// ----- rtl/rgb565_box_filter_downscaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_box_filter_downscaler
// crops an rgb565 raster stream and area-averages it down to the output size
// ----------------------------------------------------------------------------
//  channel  ports   handshake        beat
//  request  req_*   valid / ready    one source pixel plus start of frame
//  response rsp_*   valid / ready    one averaged output pixel
//  config   csr_*   write enable     one register write, no wait
//
//  a pixel outside every box skips the divider; inside a box, it takes a division
//  per box edge, and a box that completes adds one per colour channel; all of them
//  share the one bit-serial divider, and no new pixel is taken until they end.
//  NUM_W = log2(MAX_LINE_PIXELS) + log2(MAX_ROWS) + 15, 34 by default.
//  the next pixel is taken while a finished result waits on rsp_ready.
//  reset is synchronous; the column sum ram needs no clearing pass.
// ----------------------------------------------------------------------------
module rgb565_box_filter_downscaler #(
   parameter int MAX_LINE_PIXELS = rbd_pkg::DEF_MAX_LINE_PIXELS,
   parameter int MAX_ROWS        = rbd_pkg::DEF_MAX_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [rbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rbd_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [15:0]                    req_pixel,
   input  logic                           req_start_of_frame,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_blue,
   output logic [7:0]                     rsp_green,
   output logic [7:0]                     rsp_red,
   output logic [7:0]                     rsp_gray,
   output logic                           rsp_end_of_row,
   output logic                           rsp_end_of_image
);
   import rbd_pkg::*;

   rbd_cmd_type  cmd;
   rbd_stat_type stat;

   rbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rbd_dp #(
      .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
      .MAX_ROWS        (MAX_ROWS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_pixel          (req_pixel),
      .req_start_of_frame (req_start_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_blue           (rsp_blue),
      .rsp_green          (rsp_green),
      .rsp_red            (rsp_red),
      .rsp_gray           (rsp_gray),
      .rsp_end_of_row     (rsp_end_of_row),
      .rsp_end_of_image   (rsp_end_of_image),
      .cmd                (cmd),
      .stat               (stat)
   );
endmodule
